@@ rtl/bb_pkg.sv @@
// Shared types, constants and helpers for the bouncing ball tick block.
// Used by bb_alu, bb_seq and bouncing_ball_step; depends on nothing.
package bb_pkg;

  // Screen edge in pixels; both the right wall and the floor sit there
  localparam int SCREEN_EDGE = 63;
  localparam int EDGE_Q      = SCREEN_EDGE * 256;

  typedef logic signed [15:0] q16_t;
  // Working width for full precision sums and compares
  typedef logic signed [19:0] wide_t;

  localparam wide_t EDGE_W = wide_t'(EDGE_Q);

  // Config register indexes
  localparam logic [2:0] CFG_GRAVITY = 3'd0;
  localparam logic [2:0] CFG_BOUNCE  = 3'd1;
  localparam logic [2:0] CFG_DRAG    = 3'd2;
  localparam logic [2:0] CFG_STOP    = 3'd3;
  localparam logic [2:0] CFG_RADIUS  = 3'd4;

  localparam int CFG_DATA_W = 14;

  typedef struct packed {
    logic [13:0] gravity_accel;  // signed Q6.8
    logic [8:0]  bounce_factor;
    logic [8:0]  floor_drag;
    logic [12:0] stop_speed;
    logic [13:0] ball_radius;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SCALE,
    ALU_BOUNCE
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [15:0] a;
    logic [15:0] b;
    logic [8:0]  f;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAV,
    ST_POSX,
    ST_POSY,
    ST_LEFT,
    ST_RIGHT,
    ST_FLOOR,
    ST_DRAG,
    ST_STOP,
    ST_CEIL,
    ST_DONE
  } state_t;

  function automatic q16_t sat16(input wide_t v);
    q16_t r;
    if (v > wide_t'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < wide_t'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/bouncing_ball_step.sv @@
// Top level of the bouncing ball tick block: config registers and the
// sequencer with its shared arithmetic unit. Depends on bb_pkg, bb_alu, bb_seq.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  func, place_x, place_y, place_vx, place_vy
//  out      from block out_valid / out_stall pos_x, pos_y, vel_x, vel_y, floor_hit
//  cfg      to block   cfg_wr               cfg_index, cfg_data
//
// A tick walks the sequencer states from accept back to idle (plus drag and
// stop on a floor hit); a place word goes straight to the done state. The
// single shared add/scale unit handles one step per cycle, one sequencer
// state per step. The output register loads as the sequencer leaves done.
// Reset (rst, synchronous) zeroes the ball and loads the default config.
// A stalled output holds the word; a finished word waits in the sequencer
// until the output register frees, and in_stall stays high meanwhile.
module bouncing_ball_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [2:0]                    cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [15:0]            place_x,
  input  logic signed [15:0]            place_y,
  input  logic signed [15:0]            place_vx,
  input  logic signed [15:0]            place_vy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            pos_x,
  output logic signed [15:0]            pos_y,
  output logic signed [15:0]            vel_x,
  output logic signed [15:0]            vel_y,
  output logic                          floor_hit
);

  bb_pkg::cfg_t     cfg;
  bb_pkg::alu_req_t alu_req;
  bb_pkg::q16_t     alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_accel <= 14'd26;
      cfg.bounce_factor <= 9'd204;
      cfg.floor_drag    <= 9'd230;
      cfg.stop_speed    <= 13'd26;
      cfg.ball_radius   <= 14'd768;
    end else if (cfg_wr) begin
      case (cfg_index)
        bb_pkg::CFG_GRAVITY: cfg.gravity_accel <= cfg_data[13:0];
        bb_pkg::CFG_BOUNCE:  cfg.bounce_factor <= cfg_data[8:0];
        bb_pkg::CFG_DRAG:    cfg.floor_drag    <= cfg_data[8:0];
        bb_pkg::CFG_STOP:    cfg.stop_speed    <= cfg_data[12:0];
        bb_pkg::CFG_RADIUS:  cfg.ball_radius   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  bb_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  bb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .place_x   (place_x),
    .place_y   (place_y),
    .place_vx  (place_vx),
    .place_vy  (place_vy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .floor_hit (floor_hit),
    .alu_req   (alu_req),
    .alu_res   (alu_res)
  );

endmodule

@@ rtl/bb_alu.sv @@
// Shared arithmetic unit: saturating add, and sign-magnitude scaling by a
// Q1.8 factor with optional negation. Depends on bb_pkg.
module bb_alu (
  input  bb_pkg::alu_req_t req,
  output bb_pkg::q16_t     res
);

  bb_pkg::wide_t sum;
  bb_pkg::wide_t scaled;
  logic [16:0]   mag;
  logic [25:0]   prod;
  logic [17:0]   p;
  logic          neg;

  always_comb begin
    sum  = bb_pkg::wide_t'($signed(req.a)) + bb_pkg::wide_t'($signed(req.b));
    mag  = req.a[15] ? (17'd0 - {1'b1, req.a}) : {1'b0, req.a};
    prod = mag * req.f;
    p    = prod[25:8];
    // truncation toward zero: scale the magnitude, then restore sign
    neg    = req.a[15] ^ (req.op == bb_pkg::ALU_BOUNCE);
    scaled = neg ? -$signed({2'b00, p}) : $signed({2'b00, p});
    case (req.op)
      bb_pkg::ALU_ADD:    res = bb_pkg::sat16(sum);
      bb_pkg::ALU_SCALE:  res = bb_pkg::sat16(scaled);
      bb_pkg::ALU_BOUNCE: res = bb_pkg::sat16(scaled);
      default:            res = bb_pkg::sat16(sum);
    endcase
  end

endmodule

@@ rtl/bb_seq.sv @@
// Tick sequencer: ball state, wall/floor/ceiling tests and the output
// register. Drives the shared bb_alu one step per cycle. Depends on bb_pkg.
module bb_seq (
  input  logic                clk,
  input  logic                rst,
  input  bb_pkg::cfg_t        cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic signed [15:0]  place_x,
  input  logic signed [15:0]  place_y,
  input  logic signed [15:0]  place_vx,
  input  logic signed [15:0]  place_vy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  pos_x,
  output logic signed [15:0]  pos_y,
  output logic signed [15:0]  vel_x,
  output logic signed [15:0]  vel_y,
  output logic                floor_hit,
  output bb_pkg::alu_req_t    alu_req,
  input  bb_pkg::q16_t        alu_res
);

  bb_pkg::state_t state, state_next;
  bb_pkg::q16_t   x, x_next, y, y_next, vx, vx_next, vy, vy_next;
  logic           hit, hit_next;
  logic           out_valid_next;
  logic           out_load;

  bb_pkg::wide_t  r_w, x_w, y_w;
  bb_pkg::q16_t   r_q, edge_minus_r;
  logic [16:0]    vx_mag, vy_mag, stop_w;
  logic           left_hit, right_hit, floor_cond, ceil_cond;

  always_comb begin
    r_w  = bb_pkg::wide_t'({6'b0, cfg.ball_radius});
    x_w  = bb_pkg::wide_t'(x);
    y_w  = bb_pkg::wide_t'(y);
    r_q  = bb_pkg::sat16(r_w);
    edge_minus_r = bb_pkg::sat16(bb_pkg::EDGE_W - r_w);
    left_hit   = x_w < r_w;
    right_hit  = (x_w + r_w) > bb_pkg::EDGE_W;
    floor_cond = (y_w + r_w) > bb_pkg::EDGE_W;
    ceil_cond  = y_w < r_w;
    vx_mag = vx[15] ? (17'd0 - {1'b1, vx}) : {1'b0, vx};
    vy_mag = vy[15] ? (17'd0 - {1'b1, vy}) : {1'b0, vy};
    stop_w = {4'b0, cfg.stop_speed};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bb_pkg::ST_IDLE;
      x         <= '0;
      y         <= '0;
      vx        <= '0;
      vy        <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      x         <= x_next;
      y         <= y_next;
      vx        <= vx_next;
      vy        <= vy_next;
      hit       <= hit_next;
      out_valid <= out_valid_next;
    end
  end

  // output word register, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x     <= x;
      pos_y     <= y;
      vel_x     <= vx;
      vel_y     <= vy;
      floor_hit <= hit;
    end
  end

  always_comb begin
    state_next = state;
    x_next     = x;
    y_next     = y;
    vx_next    = vx;
    vy_next    = vy;
    hit_next   = hit;
    out_load   = 1'b0;
    in_stall   = 1'b1;
    out_valid_next = out_valid & out_stall;

    alu_req.op = bb_pkg::ALU_ADD;
    alu_req.a  = vy;
    alu_req.b  = {{2{cfg.gravity_accel[13]}}, cfg.gravity_accel};
    alu_req.f  = cfg.bounce_factor;

    case (state)
      bb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          hit_next = 1'b0;
          if (func) begin
            x_next     = place_x;
            y_next     = place_y;
            vx_next    = place_vx;
            vy_next    = place_vy;
            state_next = bb_pkg::ST_DONE;
          end else begin
            state_next = bb_pkg::ST_GRAV;
          end
        end
      end
      bb_pkg::ST_GRAV: begin
        vy_next    = alu_res;
        state_next = bb_pkg::ST_POSX;
      end
      bb_pkg::ST_POSX: begin
        alu_req.a  = x;
        alu_req.b  = vx;
        x_next     = alu_res;
        state_next = bb_pkg::ST_POSY;
      end
      bb_pkg::ST_POSY: begin
        alu_req.a  = y;
        alu_req.b  = vy;
        y_next     = alu_res;
        state_next = bb_pkg::ST_LEFT;
      end
      bb_pkg::ST_LEFT: begin
        alu_req.op = bb_pkg::ALU_BOUNCE;
        alu_req.a  = vx;
        if (left_hit) begin
          x_next  = r_q;
          vx_next = alu_res;
        end
        state_next = bb_pkg::ST_RIGHT;
      end
      bb_pkg::ST_RIGHT: begin
        // sees x after the left wall, so a huge radius bounces twice
        alu_req.op = bb_pkg::ALU_BOUNCE;
        alu_req.a  = vx;
        if (right_hit) begin
          x_next  = edge_minus_r;
          vx_next = alu_res;
        end
        state_next = bb_pkg::ST_FLOOR;
      end
      bb_pkg::ST_FLOOR: begin
        alu_req.op = bb_pkg::ALU_BOUNCE;
        alu_req.a  = vy;
        if (floor_cond) begin
          hit_next   = 1'b1;
          y_next     = edge_minus_r;
          vy_next    = alu_res;
          state_next = bb_pkg::ST_DRAG;
        end else begin
          state_next = bb_pkg::ST_CEIL;
        end
      end
      bb_pkg::ST_DRAG: begin
        alu_req.op = bb_pkg::ALU_SCALE;
        alu_req.a  = vx;
        alu_req.f  = cfg.floor_drag;
        vx_next    = alu_res;
        state_next = bb_pkg::ST_STOP;
      end
      bb_pkg::ST_STOP: begin
        if (vx_mag < stop_w) begin
          vx_next = '0;
        end
        if (vy_mag < stop_w) begin
          vy_next = '0;
        end
        state_next = bb_pkg::ST_CEIL;
      end
      bb_pkg::ST_CEIL: begin
        alu_req.op = bb_pkg::ALU_BOUNCE;
        alu_req.a  = vy;
        if (ceil_cond) begin
          y_next  = r_q;
          vy_next = alu_res;
        end
        state_next = bb_pkg::ST_DONE;
      end
      bb_pkg::ST_DONE: begin
        // wait here only while the previous word is still held
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
